[sv/indexed_min_heap_core_macros.svh]
// Assertion helpers shared by the heap RTL
`ifndef INDEXED_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_CORE_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define IMH_ASSERT_IMPL(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[sv/imh_pkg.sv]
package imh_pkg;
    localparam int unsigned CAPACITY  = 256;
    localparam int unsigned SLOT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned ADDR_W    = $clog2(CAPACITY);
    localparam int unsigned VTX_W     = 8;
    localparam int unsigned NUM_VERTS = 256;
    localparam int unsigned KEY_W     = 32;

    localparam logic       FUNC_INSERT = 1'b0;
    localparam logic       FUNC_DELETE = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;
endpackage

[sv/imh_ram.sv]
module imh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/indexed_min_heap_core.sv]
// Indexed binary min-heap of vertex ids ordered by a per-vertex key.
// Request channel: drive i_func, i_vertex, i_key_value, i_slot with i_start
// high; the request is taken on an edge where o_busy is low. o_busy rises
// the next cycle and stays high until the cycle that carries the result.
// Result channel: o_done pulses for one cycle with o_status, o_min_vertex,
// o_min_key, o_count; the receiver cannot stall and must take it then.
// A sequencer drives simple dual-port memories (slot->vertex, vertex->key,
// vertex->slot), each with one write port and one registered read port;
// every sift level reads slots and keys one at a time.
// An insert places the entry in the new last slot and sifts it up. A delete
// of the last slot only drops it; any other delete moves the last entry into
// the freed slot and sifts it down, and one that does not move down
// continues as an up sift. Errors change nothing. The root of a nonempty
// heap is then read for the result.
// A new request is taken in the cycle that carries the result and not
// before, so only one request is worked on at a time.
// Reset empties the heap at once (count to zero); memory contents are
// left as they are and are only read after being written.
module indexed_min_heap_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_func,
    input  logic [imh_pkg::VTX_W-1:0] i_vertex,
    input  logic [imh_pkg::KEY_W-1:0] i_key_value,
    input  logic [imh_pkg::SLOT_W-1:0] i_slot,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [imh_pkg::VTX_W-1:0] o_min_vertex,
    output logic [imh_pkg::KEY_W-1:0] o_min_key,
    output logic [imh_pkg::SLOT_W-1:0] o_count
);
    import imh_pkg::*;
    `include "indexed_min_heap_core_macros.svh"

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RDV    = 15'b000000000000010, // read heap slot r_addr
        S_RDVW   = 15'b000000000000100,
        S_RDK    = 15'b000000000001000, // read key of r_rv
        S_RDKW   = 15'b000000000010000,
        S_DISP   = 15'b000000000100000, // use fetched vertex/key
        S_WH     = 15'b000000001000000, // write heap slot
        S_WP     = 15'b000000010000000, // write position map
        S_WH2    = 15'b000000100000000,
        S_WP2    = 15'b000001000000000,
        S_DECIDE = 15'b000010000000000,
        S_RES    = 15'b000100000000000,
        S_RESW   = 15'b001000000000000,
        S_RESK   = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    // what the current fetch is for
    typedef enum logic [2:0] {
        F_MOVE  = 3'd0, // fetch last entry on delete
        F_CUR   = 3'd1, // fetch key of current entry
        F_PAR   = 3'd2, // fetch parent
        F_LEFT  = 3'd3,
        F_RIGHT = 3'd4,
        F_ROOT  = 3'd5
    } t_fetch;

    t_state r_state, n_state;
    t_fetch r_fetch;
    logic   r_up;
    logic [1:0]        r_status;
    logic [SLOT_W-1:0] r_count, r_pos, r_addr, r_child;
    logic [VTX_W-1:0]  r_cur_v, r_oth_v, r_rv;
    logic [KEY_W-1:0]  r_cur_k, r_oth_k, r_lk;
    logic [VTX_W-1:0]  r_lv;
    logic [VTX_W-1:0]  r_min_v;
    logic [KEY_W-1:0]  r_min_k;
    logic              r_done;
    // start slot of a delete, to tell whether the sift down moved
    logic [SLOT_W-1:0] r_slot0;

    // memory ports
    logic              hs_we, vk_we, vs_we;
    logic [ADDR_W-1:0] hs_waddr, hs_raddr;
    logic [VTX_W-1:0]  hs_wdata, hs_rdata, vk_waddr, vk_raddr, vs_waddr;
    logic [KEY_W-1:0]  vk_wdata, vk_rdata;
    logic [SLOT_W-1:0] vs_wdata, vs_rdata;

    // slot s (1-based) lives at address s-1
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] t;
        t = s - SLOT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    imh_ram #(.WIDTH(VTX_W), .DEPTH(CAPACITY)) u_heap_slots (
        .i_clk(i_clk), .i_we(hs_we), .i_waddr(hs_waddr), .i_wdata(hs_wdata),
        .i_raddr(hs_raddr), .o_rdata(hs_rdata));
    imh_ram #(.WIDTH(KEY_W), .DEPTH(NUM_VERTS)) u_vertex_keys (
        .i_clk(i_clk), .i_we(vk_we), .i_waddr(vk_waddr), .i_wdata(vk_wdata),
        .i_raddr(vk_raddr), .o_rdata(vk_rdata));
    imh_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_VERTS)) u_vertex_slots (
        .i_clk(i_clk), .i_we(vs_we), .i_waddr(vs_waddr), .i_wdata(vs_wdata),
        .i_raddr(vk_raddr), .o_rdata(vs_rdata));

    logic start_ok;
    assign start_ok = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // comparator used by the sift decision: other entry strictly below current
    logic oth_lt;
    assign oth_lt = (r_oth_k < r_cur_k);

    always_comb begin
        hs_we    = 1'b0;
        hs_waddr = slot_addr(r_pos);
        hs_wdata = r_cur_v;
        hs_raddr = slot_addr(r_addr);
        vk_we    = start_ok && (i_func == FUNC_INSERT) && (r_count != SLOT_W'(CAPACITY));
        vk_waddr = i_vertex;
        vk_wdata = i_key_value;
        vk_raddr = r_rv;
        vs_we    = 1'b0;
        vs_waddr = r_cur_v;
        vs_wdata = r_pos;
        case (r_state)
            S_WH:  hs_we = 1'b1;
            S_WP:  vs_we = 1'b1;
            S_WH2: begin
                hs_we    = 1'b1;
                hs_wdata = r_oth_v;
            end
            S_WP2: begin
                vs_we    = 1'b1;
                vs_waddr = r_oth_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (start_ok) begin
                    r_status <= ST_OK;
                    if (i_func == FUNC_INSERT) begin
                        if (r_count == SLOT_W'(CAPACITY)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_RES;
                        end else begin
                            r_count <= r_count + SLOT_W'(1);
                            r_pos   <= r_count + SLOT_W'(1);
                            r_cur_v <= i_vertex;
                            r_cur_k <= i_key_value;
                            r_up    <= 1'b1;
                            r_state <= S_WH; // place, then sift up
                        end
                    end else if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_RES;
                    end else if (i_slot == '0 || i_slot > r_count) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_RES;
                    end else begin
                        r_count <= r_count - SLOT_W'(1);
                        r_pos   <= i_slot;
                        if (i_slot == r_count) begin
                            r_state <= S_RES;
                        end else begin
                            r_addr  <= r_count;
                            r_fetch <= F_MOVE;
                            r_up    <= 1'b0;
                            r_state <= S_RDV;
                        end
                    end
                end
                S_RDV:  r_state <= S_RDVW;
                S_RDVW: begin
                    r_rv    <= hs_rdata;
                    r_state <= S_RDK;
                end
                S_RDK:  r_state <= S_RDKW;
                S_RDKW: r_state <= S_DISP;
                S_DISP: begin
                    case (r_fetch)
                        F_MOVE: begin
                            r_cur_v <= r_rv;
                            r_cur_k <= vk_rdata;
                            r_state <= S_WH;
                        end
                        F_PAR: begin
                            r_oth_v <= r_rv;
                            r_oth_k <= vk_rdata;
                            r_state <= S_DECIDE;
                        end
                        F_LEFT: begin
                            r_lv <= r_rv;
                            r_lk <= vk_rdata;
                            if ({1'b0, r_child} + 1'b1 <= {1'b0, r_count}) begin
                                r_addr  <= r_child + SLOT_W'(1);
                                r_fetch <= F_RIGHT;
                                r_state <= S_RDV;
                            end else begin
                                r_oth_v <= r_rv;
                                r_oth_k <= vk_rdata;
                                r_state <= S_DECIDE;
                            end
                        end
                        F_RIGHT: begin
                            // right wins unless left strictly smaller
                            if (r_lk < vk_rdata) begin
                                r_oth_v <= r_lv;
                                r_oth_k <= r_lk;
                            end else begin
                                r_oth_v <= r_rv;
                                r_oth_k <= vk_rdata;
                                r_child <= r_child + SLOT_W'(1);
                            end
                            r_state <= S_DECIDE;
                        end
                        F_ROOT: begin
                            r_min_v <= r_rv;
                            r_min_k <= vk_rdata;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_WH: r_state <= S_WP;
                S_WP: begin
                    // current entry sits at r_pos: look at a neighbor
                    if (r_up) begin
                        if (r_pos > SLOT_W'(1)) begin
                            r_child <= r_pos >> 1;
                            r_addr  <= r_pos >> 1;
                            r_fetch <= F_PAR;
                            r_state <= S_RDV;
                        end else begin
                            r_state <= S_RES;
                        end
                    end else if ({r_pos, 1'b0} <= {1'b0, r_count}) begin
                        r_child <= SLOT_W'({r_pos, 1'b0});
                        r_addr  <= SLOT_W'({r_pos, 1'b0});
                        r_fetch <= F_LEFT;
                        r_state <= S_RDV;
                    end else begin
                        r_up    <= 1'b1; // no move down: try up
                        r_state <= S_WP;
                    end
                end
                S_DECIDE: begin
                    if (r_up ? !oth_lt && (r_cur_k < r_oth_k) : oth_lt) begin
                        r_state <= S_WH2;
                    end else if (!r_up && r_fetch != F_PAR) begin
                        // stopped going down; sift up only if never moved
                        if (r_pos == r_slot0) begin
                            r_up    <= 1'b1;
                            r_state <= S_WP;
                        end else begin
                            r_state <= S_RES;
                        end
                    end else begin
                        r_state <= S_RES;
                    end
                end
                // swap: other entry goes to r_pos, current to r_child
                S_WH2: begin
                    r_state <= S_WP2;
                end
                S_WP2: begin
                    r_child <= r_pos;
                    r_pos   <= r_child;
                    r_state <= S_WH;
                end
                S_RES: begin
                    if (r_count == '0) begin
                        r_min_v <= '0;
                        r_min_k <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_addr  <= SLOT_W'(1);
                        r_fetch <= F_ROOT;
                        r_state <= S_RDV;
                    end
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_ok) begin
            r_slot0 <= i_slot;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_min_vertex = r_min_v;
    assign o_min_key    = r_min_k;
    assign o_count      = r_count;

    `IMH_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= SLOT_W'(CAPACITY), "count beyond capacity")
    `IMH_ASSERT_NEXT(a_done_after_out, i_clk, i_rst_n, r_state == S_OUT,
        o_done && !o_busy, "result not issued after output state")
    `IMH_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done,
        !o_busy || $past(r_state) == S_OUT, "result strobe while working")
    `IMH_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, o_done && o_count == '0,
        o_min_vertex == '0 && o_min_key == '0, "empty heap reports nonzero minimum")
endmodule

[verif/tb_top.sv]
module tb_top;
    import imh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct packed {
        logic [1:0]        status;
        logic [VTX_W-1:0]  min_vertex;
        logic [KEY_W-1:0]  min_key;
        logic [SLOT_W-1:0] count;
    } heap_answer_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              i_func = FUNC_INSERT;
    logic [VTX_W-1:0]  i_vertex = '0;
    logic [KEY_W-1:0]  i_key_value = '0;
    logic [SLOT_W-1:0] i_slot = '0;
    logic              o_busy;
    logic              o_done;
    logic [1:0]        o_status;
    logic [VTX_W-1:0]  o_min_vertex;
    logic [KEY_W-1:0]  o_min_key;
    logic [SLOT_W-1:0] o_count;

    indexed_min_heap_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // shadow heap
    logic [VTX_W-1:0]  slot_vertex [1:CAPACITY];
    logic [KEY_W-1:0]  vertex_key  [0:NUM_VERTS-1];
    logic [SLOT_W-1:0] vertex_pos  [0:NUM_VERTS-1];
    int unsigned       heap_count = 0;

    heap_answer_t answer_q[$];
    int  mismatches = 0;
    int  idle_pct = 0;
    int  quiet_cycles = 0;
    bit  timed_out = 0;

    function automatic logic [KEY_W-1:0] slot_key(int unsigned s);
        return vertex_key[slot_vertex[s]];
    endfunction

    task automatic swap_entries(int unsigned a, int unsigned b);
        logic [VTX_W-1:0] va, vb;
        va = slot_vertex[a];
        vb = slot_vertex[b];
        slot_vertex[a] = vb;
        slot_vertex[b] = va;
        vertex_pos[vb] = SLOT_W'(a);
        vertex_pos[va] = SLOT_W'(b);
    endtask

    task automatic bubble_up(int unsigned s);
        while (s > 1 && slot_key(s) < slot_key(s >> 1)) begin
            swap_entries(s, s >> 1);
            s = s >> 1;
        end
    endtask

    task automatic bubble_down(int unsigned s, output int unsigned final_slot);
        int unsigned c;
        while (2 * s <= heap_count) begin
            c = 2 * s;
            // right child wins ties
            if (c + 1 <= heap_count && !(slot_key(c) < slot_key(c + 1)))
                c = c + 1;
            if (!(slot_key(c) < slot_key(s)))
                break;
            swap_entries(s, c);
            s = c;
        end
        final_slot = s;
    endtask

    task automatic predict_heap(logic f, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k,
                                logic [SLOT_W-1:0] s);
        heap_answer_t a;
        int unsigned last, landed;
        a.status = ST_OK;
        if (f == FUNC_INSERT) begin
            if (heap_count >= CAPACITY) begin
                a.status = ST_FULL;
            end else begin
                vertex_key[v] = k;
                heap_count++;
                slot_vertex[heap_count] = v;
                vertex_pos[v] = SLOT_W'(heap_count);
                bubble_up(heap_count);
            end
        end else if (heap_count == 0) begin
            a.status = ST_EMPTY;
        end else if (s == 0 || s > heap_count) begin
            a.status = ST_RANGE;
        end else begin
            last = heap_count;
            heap_count--;
            if (s != last) begin
                slot_vertex[s] = slot_vertex[last];
                vertex_pos[slot_vertex[s]] = s;
                bubble_down(s, landed);
                if (landed == s)
                    bubble_up(s);
            end
        end
        a.min_vertex = heap_count > 0 ? slot_vertex[1] : '0;
        a.min_key    = heap_count > 0 ? slot_key(1) : '0;
        a.count      = SLOT_W'(heap_count);
        answer_q.push_back(a);
    endtask

    task automatic send_request(logic f, logic [VTX_W-1:0] v, logic [KEY_W-1:0] k,
                                logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
        @(negedge i_clk);
        i_start     = 1'b1;
        i_func      = f;
        i_vertex    = v;
        i_key_value = k;
        i_slot      = s;
        forever begin
            @(posedge i_clk);
            if (!o_busy)
                break;
        end
        predict_heap(f, v, k, s);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        heap_answer_t want, got;
        if (i_rst_n && o_done) begin
            got = '{o_status, o_min_vertex, o_min_key, o_count};
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = answer_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic test_empty_errors();
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd1);
        send_request(FUNC_DELETE, 8'hFF, 32'hFFFF_FFFF, 9'd0);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'h1FF);
    endtask

    task automatic test_directed_ops();
        send_request(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
        send_request(FUNC_INSERT, 8'h00, 32'h0000_0000, 9'd0);
        send_request(FUNC_INSERT, 8'h55, 32'h8000_0000, 9'd3);
        send_request(FUNC_INSERT, 8'hAA, 32'h8000_0000, 9'd3);
        send_request(FUNC_INSERT, 8'h01, 32'h7FFF_FFFF, 9'd3);
        // duplicate vertex: key overwritten, second entry appended
        send_request(FUNC_INSERT, 8'h55, 32'h0000_0001, 9'd3);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd0);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd7);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd6);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd2);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd1);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd1);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd2);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd1);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd1);
    endtask

    task automatic test_full_heap();
        for (int i = 0; i < CAPACITY; i++)
            send_request(FUNC_INSERT, i[7:0], $urandom_range(0, 63), 9'd0);
        send_request(FUNC_INSERT, 8'h12, 32'h0, 9'd1);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'h101);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd256);
        send_request(FUNC_DELETE, 8'h00, 32'h0, 9'd128);
        while (heap_count > 0)
            send_request(FUNC_DELETE, 8'h00, 32'h0,
                         SLOT_W'($urandom_range(1, heap_count)));
    endtask

    task automatic test_random_mix(int n);
        logic [KEY_W-1:0] k;
        logic [SLOT_W-1:0] s;
        for (int i = 0; i < n; i++) begin
            k = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 31);
            if ($urandom_range(19) == 0)
                s = SLOT_W'($urandom_range(0, 511));
            else
                s = heap_count > 0 ? SLOT_W'($urandom_range(1, heap_count)) : 9'd1;
            if (heap_count == 0 ? $urandom_range(9) != 0
                                : $urandom_range(99) < (heap_count < 40 ? 60 : 40))
                send_request(FUNC_INSERT, VTX_W'($urandom_range(0, 255)), k,
                             SLOT_W'($urandom_range(0, 511)));
            else
                send_request(FUNC_DELETE, VTX_W'($urandom_range(0, 255)), k, s);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_pct = 16;
        test_empty_errors();
        test_directed_ops();
        test_full_heap();
        test_random_mix(550);
        // hold until the heap has answered everything
        wait_idle();
        idle_pct = 62;
        test_random_mix(450);
        idle_pct = 0;
        test_random_mix(550);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/imh_pkg.sv
sv/imh_ram.sv
sv/indexed_min_heap_core.sv
verif/tb_top.sv
